### hdl/sha256_pkg.sv
// shared types, constants and functions for the sha-256 digest block
// no dependencies
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_PAD    = 8'b0000_0010,
    ST_LEN_HI = 8'b0000_0100,
    ST_LEN_LO = 8'b0000_1000,
    ST_LOAD   = 8'b0001_0000,
    ST_ROUND  = 8'b0010_0000,
    ST_FINAL  = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [5:0] LEN_POSITION = 6'd56;
  localparam logic [3:0] LEN_HI_WORD  = 4'd14;
  localparam logic [3:0] LEN_LO_WORD  = 4'd15;
  localparam logic [5:0] LAST_ROUND   = 6'd63;
  localparam logic [2:0] LAST_INDEX   = 3'd7;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INITIAL_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

endpackage

### hdl/sha256_message_digest_top.sv
// sha-256 digest of a byte stream, block buffer in a one-port-read memory
// depends on sha256_pkg
//
// input bytes are taken only while idle; a filled block then goes through a read
// prefetch, 64 rounds at one round a cycle, and a hash update
// end of message: the pad bytes, the two length words, one or two block
// compressions, then eight result transfers, one per cycle while not stalled
// reset is synchronous: hash to initial values, length and byte slot to zero,
// block memory left as is (every word is written before a compression reads it)
module sha256_message_digest_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha256_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::out_item_t out_data
);
  import sha256_pkg::*;

  state_t      state_r, state_nxt;

  // block buffer: sixteen words, read data registered
  logic [31:0] blk_mem [16];
  logic [31:0] rd_data_r;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_data;

  // byte packing
  logic [31:0] acc_r, acc_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        pb_en;
  logic [7:0]  pb_byte;
  logic [5:0]  pos_inc;

  // end-of-message control
  logic        pad_r, pad_nxt;     // padding in progress
  logic        mark_r, mark_nxt;   // 0x80 byte already placed
  logic        fin_r, fin_nxt;     // length block under compression

  // compression
  logic [5:0]  rnd_r, rnd_nxt;
  logic [31:0] hash_r [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] sched_new, w_t, t1, t2, ch, maj;

  logic [2:0]  idx_r, idx_nxt;
  logic        in_xfer, out_xfer;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);
  assign out_xfer  = out_valid && !out_stall;

  assign out_data.digest_word = hash_r[idx_r];
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == LAST_INDEX);

  // round datapath
  assign sched_new = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];
  assign w_t = rnd_r[5:4] == 2'b00 ? rd_data_r : sched_new;
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + big_sigma1(v_r[4]) + ch + ROUND_K[rnd_r] + w_t;
  assign t2  = big_sigma0(v_r[0]) + maj;

  // memory read address: prefetch word 0, then one ahead of the round
  assign rd_addr = (state_r == ST_ROUND) ? rnd_r[3:0] + 4'd1 : 4'd0;
  assign pos_inc = pos_r + 6'd1;

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    bits_nxt  = bits_r;
    pad_nxt   = pad_r;
    mark_nxt  = mark_r;
    fin_nxt   = fin_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    hash_nxt  = hash_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    pb_en     = 1'b0;
    pb_byte   = 8'h00;
    wr_en     = 1'b0;
    wr_addr   = pos_r[5:2];
    wr_data   = 32'h0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          pb_en    = in_data.byte_present;
          pb_byte  = in_data.data_byte;
          pad_nxt  = in_data.end_of_message;
          mark_nxt = 1'b0;
          if (in_data.byte_present) begin
            bits_nxt = bits_r + 64'd8;
          end
          if (in_data.byte_present && pos_inc == 6'd0) begin
            state_nxt = ST_LOAD;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        pb_en    = 1'b1;
        pb_byte  = mark_r ? 8'h00 : PAD_BYTE;
        mark_nxt = 1'b1;
        if (pos_inc == 6'd0) begin
          state_nxt = ST_LOAD;
        end else if (pos_inc == LEN_POSITION) begin
          state_nxt = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        wr_en     = 1'b1;
        wr_addr   = LEN_HI_WORD;
        wr_data   = bits_r[63:32];
        state_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        wr_en     = 1'b1;
        wr_addr   = LEN_LO_WORD;
        wr_data   = bits_r[31:0];
        pos_nxt   = 6'd0;
        fin_nxt   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        v_nxt     = hash_r;
        rnd_nxt   = 6'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_t;
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + v_r[i];
        end
        if (fin_r) begin
          idx_nxt   = 3'd0;
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_INDEX) begin
            hash_nxt  = INITIAL_HASH;
            bits_nxt  = 64'd0;
            pos_nxt   = 6'd0;
            pad_nxt   = 1'b0;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // byte placement, big-endian within the word; full words go to memory
    if (pb_en) begin
      acc_nxt[8*(3 - pos_r[1:0]) +: 8] = pb_byte;
      pos_nxt = pos_inc;
      if (pos_r[1:0] == 2'b11) begin
        wr_en   = 1'b1;
        wr_addr = pos_r[5:2];
        wr_data = acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= blk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= 6'd0;
      bits_r  <= 64'd0;
      pad_r   <= 1'b0;
      mark_r  <= 1'b0;
      fin_r   <= 1'b0;
      rnd_r   <= 6'd0;
      idx_r   <= 3'd0;
      hash_r  <= INITIAL_HASH;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      bits_r  <= bits_nxt;
      pad_r   <= pad_nxt;
      mark_r  <= mark_nxt;
      fin_r   <= fin_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      hash_r  <= hash_nxt;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    v_r   <= v_nxt;
    w_r   <= w_nxt;
  end

endmodule

### hdl/sha256_checker.sv
// port-level checks for the sha-256 digest block, bound to the top level
// depends on sha256_pkg
module sha256_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input sha256_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input sha256_pkg::out_item_t out_data
);
  import sha256_pkg::*;

  // a stalled input transfer holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no input transfer while digest words are pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during digest output");

  // last flag only on the eighth word
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == LAST_INDEX)))
    else $error("last_word mismatch");

  // words follow in order without gaps
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_word |=>
      out_valid && (out_data.word_index == $past(out_data.word_index) + 3'd1))
    else $error("digest word order broken");

endmodule

bind sha256_message_digest_top sha256_checker u_sha256_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
